// ===== rtl/swik_pkg.sv =====
package swik_pkg;

  localparam int unsigned CMD_W   = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned SCL_W   = 18;
  localparam int unsigned VEC_W   = 19;
  localparam int unsigned ROT_W   = 32;
  localparam int unsigned ACC_W   = 20;
  localparam int unsigned SQ_W    = 38;
  localparam int unsigned NSTEP   = 16;
  localparam int unsigned NSQRT   = 19;

  localparam logic [1:0] REG_SPEED_SCALE = 2'd0;
  localparam logic [1:0] REG_WT          = 2'd1;
  localparam logic [1:0] REG_TW          = 2'd2;
  localparam logic [1:0] REG_DEADBAND    = 2'd3;

  typedef struct packed {
    logic signed [CMD_W-1:0] fwd_cmd;
    logic signed [CMD_W-1:0] side_cmd;
    logic signed [CMD_W-1:0] turn_cmd;
  } in_t;

  typedef struct packed {
    logic [15:0] angle_front_left;
    logic [15:0] angle_front_right;
    logic [15:0] angle_back_left;
    logic [15:0] angle_back_right;
    logic [15:0] speed_front_left;
    logic [15:0] speed_front_right;
    logic [15:0] speed_back_left;
    logic [15:0] speed_back_right;
    logic        moving;
  } out_t;

  typedef struct packed {
    logic       in_load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       comb_en;
    logic       load_en;
    logic       sq_en;
    logic       step_en;
    logic [4:0] step_idx;
    logic       store_en;
    logic [1:0] mod_idx;
    logic       out_load;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_LOAD,
    ST_SQ,
    ST_ITER,
    ST_STORE,
    ST_FINISH
  } state_t;

  function automatic logic [ACC_W-1:0] atan_lut(input logic [3:0] i);
    logic [ACC_W-1:0] v;
    unique case (i)
      4'd0:    v = 20'd131072;
      4'd1:    v = 20'd77376;
      4'd2:    v = 20'd40884;
      4'd3:    v = 20'd20753;
      4'd4:    v = 20'd10417;
      4'd5:    v = 20'd5213;
      4'd6:    v = 20'd2607;
      4'd7:    v = 20'd1304;
      4'd8:    v = 20'd652;
      4'd9:    v = 20'd326;
      4'd10:   v = 20'd163;
      4'd11:   v = 20'd81;
      4'd12:   v = 20'd41;
      4'd13:   v = 20'd20;
      4'd14:   v = 20'd10;
      default: v = 20'd5;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/swerve_inverse_kinematics.sv =====
// Channel   Ports                          Moves
// input     in_valid  in_ready  in_data    one drive command per transfer
// result    out_valid out_ready out_data   four angles, four speeds, moving flag
// config    cfg_we cfg_index cfg_data      one register write per enabled cycle
// An item is taken only after the previous one has been loaded into the output register:
// four multiplies on one shared multiplier, a combine step, then per module a load, a square
// step and the iterations of the 19-step square root running beside the 16-step CORDIC
// vectoring unit, shared by the four modules, then a store, and finally an output load.
// Reset is synchronous: config and control registers return to their defaults and held angles to zero.
// A result waits in the output register; a finished item waits in the finish state until it is taken.
module swerve_inverse_kinematics (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [swik_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  swik_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output swik_pkg::out_t             out_data
);

  swik_pkg::cmd_t cmd;

  swik_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  swik_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/swik_ctrl.sv =====
module swik_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output swik_pkg::cmd_t cmd
);

  swik_pkg::state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] mod_r, mod_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swik_pkg::ST_IDLE;
      cnt_r       <= '0;
      mod_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    mod_nxt      = mod_r;
    cmd          = '0;
    cmd.mul_sel  = cnt_r[1:0];
    cmd.step_idx = cnt_r;
    cmd.mod_idx  = mod_r;
    in_ready     = 1'b0;
    unique case (state_r)
      swik_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = swik_pkg::ST_MUL;
        end
      end
      swik_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == 5'd3) state_nxt = swik_pkg::ST_COMB;
      end
      swik_pkg::ST_COMB: begin
        cmd.comb_en = 1'b1;
        mod_nxt     = '0;
        state_nxt   = swik_pkg::ST_LOAD;
      end
      swik_pkg::ST_LOAD: begin
        cmd.load_en = 1'b1;
        state_nxt   = swik_pkg::ST_SQ;
      end
      swik_pkg::ST_SQ: begin
        cmd.sq_en = 1'b1;
        cnt_nxt   = '0;
        state_nxt = swik_pkg::ST_ITER;
      end
      swik_pkg::ST_ITER: begin
        cmd.step_en = 1'b1;
        cnt_nxt     = cnt_r + 5'd1;
        if (cnt_r == 5'(swik_pkg::NSQRT - 1)) state_nxt = swik_pkg::ST_STORE;
      end
      swik_pkg::ST_STORE: begin
        cmd.store_en = 1'b1;
        mod_nxt      = mod_r + 2'd1;
        if (mod_r == 2'd3) state_nxt = swik_pkg::ST_FINISH;
        else state_nxt = swik_pkg::ST_LOAD;
      end
      swik_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = swik_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swik_pkg::ST_IDLE;
    endcase
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/swik_dp.sv =====
module swik_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [swik_pkg::CFG_W-1:0]     cfg_data,
  input  swik_pkg::in_t                  in_data,
  input  swik_pkg::cmd_t                 cmd,
  output swik_pkg::out_t                 out_data
);

  localparam int unsigned VW = swik_pkg::VEC_W;
  localparam int unsigned RW = swik_pkg::ROT_W;
  localparam int unsigned AW = swik_pkg::ACC_W;
  localparam int unsigned QW = swik_pkg::SQ_W;

  logic [15:0] scale_r, wt_r, tw_r;
  logic [14:0] db_r;
  swik_pkg::in_t in_r;
  logic signed [swik_pkg::SCL_W-1:0] f_r, s_r, rw_r, rt_r;
  logic signed [VW-1:0] a_r, b_r, c_r, d_r;
  logic moving_r;
  logic signed [RW-1:0] cx_r, cy_r;
  logic [AW-1:0] acc_r;
  logic zero_r;
  logic [QW-1:0] sqx_r, n_r, res_r, bit_r;
  logic [15:0] held_r [4];
  logic [15:0] spd_r [4];
  swik_pkg::out_t out_r;

  logic signed [16:0] mop_a, mop_b;
  logic signed [33:0] prod;
  logic signed [VW-1:0] vy, vx;
  logic signed [2*VW-1:0] vsq;
  logic signed [RW-1:0] xs, ys, x0, y0;
  logic [QW-1:0] trial;
  logic [AW-1:0] acc_rnd;
  logic [15:0] ang;
  logic [16:0] spd_raw;

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 16'd16384;
      wt_r    <= 16'd16384;
      tw_r    <= 16'd16384;
      db_r    <= 15'd1638;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swik_pkg::REG_SPEED_SCALE: scale_r <= cfg_data;
        swik_pkg::REG_WT:          wt_r    <= cfg_data;
        swik_pkg::REG_TW:          tw_r    <= cfg_data;
        swik_pkg::REG_DEADBAND:    db_r    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      2'd0:    mop_a = 17'(in_r.fwd_cmd);
      2'd1:    mop_a = 17'(in_r.side_cmd);
      default: mop_a = 17'(in_r.turn_cmd);
    endcase
    case (cmd.mul_sel)
      2'd2:    mop_b = $signed({1'b0, wt_r});
      2'd3:    mop_b = $signed({1'b0, tw_r});
      default: mop_b = $signed({1'b0, scale_r});
    endcase
    prod = mop_a * mop_b;
  end

  always_comb begin
    case (cmd.mod_idx)
      2'd0:    begin vy = b_r; vx = c_r; end
      2'd1:    begin vy = b_r; vx = d_r; end
      2'd2:    begin vy = a_r; vx = d_r; end
      default: begin vy = a_r; vx = c_r; end
    endcase
    x0 = RW'(vx) <<< 10;
    y0 = RW'(vy) <<< 10;
    vsq = cmd.sq_en ? vy * vy : vx * vx;
    xs = cx_r >>> cmd.step_idx[3:0];
    ys = cy_r >>> cmd.step_idx[3:0];
    trial = res_r + bit_r;
    acc_rnd = acc_r + AW'(8);
    ang = zero_r ? 16'd32768 : acc_rnd[AW-1:4] + 16'd32768;
    spd_raw = res_r[18:2];
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) in_r <= in_data;
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        2'd0:    f_r  <= prod[31:14];
        2'd1:    s_r  <= prod[31:14];
        2'd2:    rw_r <= prod[31:14];
        default: rt_r <= prod[31:14];
      endcase
    end
    if (cmd.comb_en) begin
      a_r <= VW'(s_r) - VW'(rw_r);
      b_r <= VW'(s_r) + VW'(rw_r);
      c_r <= VW'(f_r) - VW'(rt_r);
      d_r <= VW'(f_r) + VW'(rt_r);
      moving_r <= (mag(VW'(f_r)) > VW'(db_r)) || (mag(VW'(s_r)) > VW'(db_r)) ||
                  (mag(VW'(in_r.turn_cmd)) > VW'(db_r));
    end
    if (cmd.load_en) begin
      zero_r <= (vx == '0) && (vy == '0);
      sqx_r  <= QW'(unsigned'(vsq));
      if (vx[VW-1]) begin
        cx_r  <= -x0;
        cy_r  <= -y0;
        acc_r <= AW'(1) << (AW-1);
      end else begin
        cx_r  <= x0;
        cy_r  <= y0;
        acc_r <= '0;
      end
    end
    if (cmd.sq_en) begin
      n_r   <= sqx_r + QW'(unsigned'(vsq));
      res_r <= '0;
      bit_r <= QW'(1) << (2*(swik_pkg::NSQRT-1));
    end
    if (cmd.step_en) begin
      if (cmd.step_idx < 5'(swik_pkg::NSTEP)) begin
        if (cy_r > 0) begin
          cx_r  <= cx_r + ys;
          cy_r  <= cy_r - xs;
          acc_r <= acc_r + swik_pkg::atan_lut(cmd.step_idx[3:0]);
        end else begin
          cx_r  <= cx_r - ys;
          cy_r  <= cy_r + xs;
          acc_r <= acc_r - swik_pkg::atan_lut(cmd.step_idx[3:0]);
        end
      end
      if (n_r >= trial) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.store_en) begin
      spd_r[cmd.mod_idx] <= spd_raw[16] ? 16'hFFFF : spd_raw[15:0];
    end
    if (cmd.out_load) begin
      out_r.angle_front_left  <= held_r[0];
      out_r.angle_front_right <= held_r[1];
      out_r.angle_back_left   <= held_r[2];
      out_r.angle_back_right  <= held_r[3];
      out_r.speed_front_left  <= spd_r[0];
      out_r.speed_front_right <= spd_r[1];
      out_r.speed_back_left   <= spd_r[2];
      out_r.speed_back_right  <= spd_r[3];
      out_r.moving            <= moving_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) held_r[i] <= '0;
    end else if (cmd.store_en && moving_r) begin
      held_r[cmd.mod_idx] <= ang;
    end
  end

  assign out_data = out_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [swik_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  swik_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  swik_pkg::out_t out_data;

  swerve_inverse_kinematics dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  localparam int CYCLE_LIMIT = 2000000;
  localparam int N_RANDOM = 1700;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    swik_pkg::in_t cmd;
    logic use_exp;
    swik_pkg::out_t exp;
  } stim_row_t;

  logic [15:0] scale_q, wt_q, tw_q;
  logic [14:0] deadband_q;
  logic [15:0] held_q [4];
  swik_pkg::out_t kin_queue [$];
  int errors;
  int cycles;
  logic hold_off;
  logic quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("swerve_inverse_kinematics verification failed");
        $finish;
      end
    end
  end

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic [15:0] mag_of(longint y, longint x);
    longint unsigned n, r, b;
    n = y * y + x * x;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    r = r >> 2;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic [15:0] heading_of(longint y, longint x);
    logic [31:0] acc;
    longint xs, ys;
    if (x == 0 && y == 0) return 16'd32768;
    acc = 0;
    x = x * 1024;
    y = y * 1024;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'd524288;
    end
    for (int i = 0; i < swik_pkg::NSTEP; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + swik_pkg::atan_lut(i[3:0]);
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - swik_pkg::atan_lut(i[3:0]);
      end
    end
    acc = ((acc + 32'd8) >> 4) + 32'd32768;
    return acc[15:0];
  endfunction

  function automatic swik_pkg::out_t predict_modules(swik_pkg::in_t c);
    swik_pkg::out_t o;
    longint f, s, r, rw, rt, ya, yb, xc, xd;
    longint ys [4];
    longint xs [4];
    logic mv;
    f = floor_shr(longint'(c.fwd_cmd) * longint'(scale_q), 14);
    s = floor_shr(longint'(c.side_cmd) * longint'(scale_q), 14);
    r = longint'(c.turn_cmd);
    rw = floor_shr(r * longint'(wt_q), 14);
    rt = floor_shr(r * longint'(tw_q), 14);
    ya = s - rw;
    yb = s + rw;
    xc = f - rt;
    xd = f + rt;
    ys[0] = yb; xs[0] = xc;
    ys[1] = yb; xs[1] = xd;
    ys[2] = ya; xs[2] = xd;
    ys[3] = ya; xs[3] = xc;
    mv = (f < 0 ? -f : f) > deadband_q || (s < 0 ? -s : s) > deadband_q ||
         (r < 0 ? -r : r) > deadband_q;
    if (mv)
      for (int i = 0; i < 4; i++) held_q[i] = heading_of(ys[i], xs[i]);
    o.angle_front_left = held_q[0];
    o.angle_front_right = held_q[1];
    o.angle_back_left = held_q[2];
    o.angle_back_right = held_q[3];
    o.speed_front_left = mag_of(ys[0], xs[0]);
    o.speed_front_right = mag_of(ys[1], xs[1]);
    o.speed_back_left = mag_of(ys[2], xs[2]);
    o.speed_back_right = mag_of(ys[3], xs[3]);
    o.moving = mv;
    return o;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      swik_pkg::REG_SPEED_SCALE: scale_q = val;
      swik_pkg::REG_WT: wt_q = val;
      swik_pkg::REG_TW: tw_q = val;
      default: deadband_q = val[14:0];
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (kin_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_cmd(swik_pkg::in_t c, logic use_exp, swik_pkg::out_t exp_o);
    swik_pkg::out_t p;
    if (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 23) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    p = predict_modules(c);
    if (use_exp && p !== exp_o) begin
      $display("%0t table row mismatch: expected %h actual %h", $time, exp_o, p);
      errors++;
    end
    kin_queue.push_back(p);
  endtask

  function automatic swik_pkg::in_t rand_cmd(int mode);
    swik_pkg::in_t c;
    c = 48'({$urandom, $urandom});
    if (mode == 1) begin
      c.fwd_cmd = 16'($urandom_range(0, 3000) - 1500);
      c.side_cmd = 16'($urandom_range(0, 3000) - 1500);
      c.turn_cmd = 16'($urandom_range(0, 3000) - 1500);
    end else if (mode == 2) begin
      c.fwd_cmd = ($urandom_range(1)) ? 16'sh8000 : 16'sh7FFF;
      c.turn_cmd = ($urandom_range(1)) ? 16'sh8000 : 16'sh7FFF;
    end
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (kin_queue.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, out_data);
        errors++;
      end else begin
        swik_pkg::out_t e;
        e = kin_queue.pop_front();
        if (e.angle_front_left !== out_data.angle_front_left ||
            e.angle_front_right !== out_data.angle_front_right ||
            e.angle_back_left !== out_data.angle_back_left ||
            e.angle_back_right !== out_data.angle_back_right ||
            e.speed_front_left !== out_data.speed_front_left ||
            e.speed_front_right !== out_data.speed_front_right ||
            e.speed_back_left !== out_data.speed_back_left ||
            e.speed_back_right !== out_data.speed_back_right ||
            e.moving !== out_data.moving) begin
          $display("%0t result mismatch: expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (800) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 23);
        @(posedge clk);
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    swik_pkg::out_t z;
    errors = 0;
    hold_off = 1'b0;
    quiet = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = swik_pkg::REG_SPEED_SCALE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    scale_q = 16384;
    wt_q = 16384;
    tw_q = 16384;
    deadband_q = 1638;
    for (int i = 0; i < 4; i++) held_q[i] = 16'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    z = '0;
    z.angle_front_left = 0;
    row.use_exp = 1'b1; row.cmd = '0; row.exp = z;
    rows.push_back(row);
    row.use_exp = 1'b0;
    row.cmd = '{16'sh7FFF, 16'sh0000, 16'sh0000}; rows.push_back(row);
    row.cmd = '{16'sh8000, 16'sh0000, 16'sh0000}; rows.push_back(row);
    row.cmd = '{16'sh0000, 16'sh7FFF, 16'sh0000}; rows.push_back(row);
    row.cmd = '{16'sh0000, 16'sh8000, 16'sh0000}; rows.push_back(row);
    row.cmd = '{16'sh0000, 16'sh0000, 16'sh7FFF}; rows.push_back(row);
    row.cmd = '{16'sh0000, 16'sh0000, 16'sh8000}; rows.push_back(row);
    row.cmd = '{16'sh8000, 16'sh8000, 16'sh8000}; rows.push_back(row);
    row.cmd = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}; rows.push_back(row);
    row.cmd = '{16'sd1638, 16'sd0, 16'sd0}; rows.push_back(row);
    row.cmd = '{16'sd1639, 16'sd0, 16'sd0}; rows.push_back(row);
    row.cmd = '{-16'sd1639, 16'sd100, 16'sd0}; rows.push_back(row);
    row.cmd = '{16'sd0, 16'sd0, 16'sd1639}; rows.push_back(row);
    row.cmd = '{16'sd5, -16'sd5, 16'sd0}; rows.push_back(row);
    row.cmd = '{-16'sd3000, 16'sd0, 16'sd0}; rows.push_back(row);
    row.cmd = '{-16'sd3000, -16'sd1, 16'sd0}; rows.push_back(row);
    row.cmd = '{16'sd1000, 16'sd1000, 16'sd1000}; rows.push_back(row);
    row.cmd = 48'hFFFF_FFFF_FFFF; rows.push_back(row);
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].use_exp, rows[i].exp);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(swik_pkg::REG_SPEED_SCALE, 16'hFFFF);
          write_reg(swik_pkg::REG_WT, 16'hFFFF);
          write_reg(swik_pkg::REG_TW, 16'hFFFF);
          write_reg(swik_pkg::REG_DEADBAND, 16'h7FFF);
        end
        1: begin
          write_reg(swik_pkg::REG_SPEED_SCALE, 16'h0000);
          write_reg(swik_pkg::REG_WT, 16'h0000);
          write_reg(swik_pkg::REG_TW, 16'h0000);
          write_reg(swik_pkg::REG_DEADBAND, 16'h0000);
        end
        2: begin
          write_reg(swik_pkg::REG_SPEED_SCALE, 16'd16384);
          write_reg(swik_pkg::REG_WT, 16'd20000);
          write_reg(swik_pkg::REG_TW, 16'd13421);
          write_reg(swik_pkg::REG_DEADBAND, 16'd1638);
        end
        default: begin
          write_reg(swik_pkg::REG_SPEED_SCALE, 16'($urandom));
          write_reg(swik_pkg::REG_WT, 16'($urandom));
          write_reg(swik_pkg::REG_TW, 16'($urandom));
          write_reg(swik_pkg::REG_DEADBAND, 16'($urandom));
        end
      endcase
      cfg_we <= 1'b0;
      quiet = (ph == 2);
      if (ph == 3) hold_off = 1'b1;
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        int m;
        m = $urandom_range(99);
        send_cmd(rand_cmd(m < 25 ? 1 : (m < 32 ? 2 : 0)), 1'b0, z);
      end
      quiet = 1'b0;
      wait_drained();
    end

    if (errors == 0)
      $display("swerve_inverse_kinematics verification clean");
    else
      $display("swerve_inverse_kinematics verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swik_pkg.sv
rtl/swik_ctrl.sv
rtl/swik_dp.sv
rtl/swerve_inverse_kinematics.sv
tb/sv/tb.sv
